@@ hw/rtl/ihex_pkg.sv @@
// shared types, constants and helper functions for the hex record encoder
// no dependencies; used by every module of the block
package ihex_pkg;

   localparam int MAX_RECORD_BYTES_DEF = 32;
   localparam int QUEUE_DEPTH_DEF      = 4;
   localparam int SHORT_LEN            = 16;
   localparam int LEN_W                = 6;
   localparam int ADDR_W               = 16;
   localparam int CSR_INDEX_W          = 1;
   localparam int CSR_DATA_W           = 13;
   localparam int COUNT_W              = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_MODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_COUNT = 1'b1;

   localparam logic [6:0] CHAR_COLON  = 7'h3A;
   localparam logic [6:0] CHAR_LF     = 7'h0A;
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_ONE    = 7'h31;
   localparam logic [6:0] CHAR_F      = 7'h46;
   localparam logic [6:0] CHAR_A_BASE = 7'h37;

   typedef struct packed {
      logic              hdr;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              trl;
      logic [7:0]        csum;
      logic              eof;
   } job_type;

   typedef enum logic [4:0] {
      ST_COLON, ST_LEN_HI, ST_LEN_LO, ST_ADR3, ST_ADR2, ST_ADR1, ST_ADR0,
      ST_TYPE_HI, ST_TYPE_LO, ST_DATA_HI, ST_DATA_LO, ST_SUM_HI, ST_SUM_LO, ST_LF,
      ST_EOF0, ST_EOF1, ST_EOF2, ST_EOF3, ST_EOF4, ST_EOF5, ST_EOF6, ST_EOF7,
      ST_EOF8, ST_EOF9, ST_EOF10, ST_EOF11
   } step_type;

   function automatic logic [6:0] hex_digit(input logic [3:0] v);
      logic [6:0] r;
      if (v < 4'd10) begin
         r = CHAR_ZERO + {3'b000, v};
      end else begin
         r = CHAR_A_BASE + {3'b000, v};
      end
      return r;
   endfunction

   // end-of-file record text ":00000001FF" and line feed
   function automatic logic [6:0] eof_char(input logic [3:0] k);
      logic [6:0] r;
      case (k)
         4'd0:    r = CHAR_COLON;
         4'd8:    r = CHAR_ONE;
         4'd9:    r = CHAR_F;
         4'd10:   r = CHAR_F;
         4'd11:   r = CHAR_LF;
         default: r = CHAR_ZERO;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/ihex_front.sv @@
// front end: config registers, record bookkeeping and checksum per byte
// depends on ihex_pkg; feeds one job per accepted byte into the queue
module ihex_front #(
   parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ihex_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                job_valid,
   output ihex_pkg::job_type                   job,
   input  logic                                job_ready
);

   localparam int BIR_W = $clog2(MAX_RECORD_BYTES);
   localparam int CNT_W = BIR_W + 1;

   logic                               mode_ff;
   logic [ihex_pkg::COUNT_W-1:0]       count_ff;
   logic [BIR_W-1:0]                   bir_ff, bir_in;
   logic [ihex_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [7:0]                         sum_ff, sum_in;
   logic [ihex_pkg::COUNT_W-1:0]       left_ff, left_in;

   logic [ihex_pkg::LEN_W-1:0]         len;
   logic [CNT_W-1:0]                   cnt;
   logic                               first;
   logic                               last_byte;
   logic [ihex_pkg::COUNT_W-1:0]       left_start;
   logic [ihex_pkg::COUNT_W-1:0]       left_dec;
   logic [7:0]                         hdr_sum;
   logic [7:0]                         sum_new;
   logic                               eof;
   logic                               take;

   assign csr_ready = 1'b1;
   assign req_ready = job_ready;
   assign take      = req_valid && job_ready;

   assign len   = mode_ff ? ihex_pkg::LEN_W'(MAX_RECORD_BYTES)
                          : ihex_pkg::LEN_W'(ihex_pkg::SHORT_LEN);
   assign first = (bir_ff == '0);
   assign cnt   = {1'b0, bir_ff} + CNT_W'(1);
   assign last_byte = (ihex_pkg::LEN_W'(cnt) >= len);

   always_comb begin
      left_start = left_ff;
      if (first && left_ff == '0) begin
         left_start = (count_ff == '0) ? ihex_pkg::COUNT_W'(1) : count_ff;
      end
   end

   assign left_dec = left_start - ihex_pkg::COUNT_W'(1);
   assign hdr_sum  = 8'(len) + addr_ff[15:8] + addr_ff[7:0];
   assign sum_new  = (first ? hdr_sum : sum_ff) + req_data_byte;
   assign eof      = last_byte && (left_dec == '0);

   always_comb begin
      bir_in  = BIR_W'(cnt);
      sum_in  = sum_new;
      addr_in = addr_ff;
      left_in = left_start;
      if (last_byte) begin
         bir_in  = '0;
         sum_in  = 8'd0;
         left_in = left_dec;
         addr_in = eof ? '0 : addr_ff + ihex_pkg::ADDR_W'(len);
      end
   end

   assign job_valid = req_valid;
   always_comb begin
      job.hdr  = first;
      job.len  = len;
      job.addr = addr_ff;
      job.data = req_data_byte;
      job.trl  = last_byte;
      job.csum = 8'd0 - sum_new;
      job.eof  = eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= ihex_pkg::COUNT_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            ihex_pkg::CSR_RECORD_MODE:  mode_ff  <= csr_data[0];
            ihex_pkg::CSR_RECORD_COUNT: count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff  <= '0;
         addr_ff <= '0;
         sum_ff  <= '0;
         left_ff <= '0;
      end else if (take) begin
         bir_ff  <= bir_in;
         addr_ff <= addr_in;
         sum_ff  <= sum_in;
         left_ff <= left_in;
      end
   end

endmodule

@@ hw/rtl/ihex_queue.sv @@
// short job queue between the front end and the character back end
// depends on ihex_pkg for the job type
module ihex_queue #(
   parameter int DEPTH = ihex_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ihex_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ihex_pkg::job_type pop_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   ihex_pkg::job_type   mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

@@ hw/rtl/ihex_back.sv @@
// back end: steps through each job's characters, one per cycle when
// not stalled; uses ihex_pkg; drives the registered result channel
module ihex_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ihex_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_char_code,
   output logic              rsp_run_last,
   output logic              rsp_image_done
);

   ihex_pkg::step_type step_ff, step_in, cur;
   logic               fresh_ff, fresh_in;
   logic               valid_ff;
   logic [6:0]         char_ff;
   logic               last_ff;
   logic               done_ff;
   logic               go;
   logic               finish;
   logic [6:0]         ch;
   logic [3:0]         eof_k;
   logic [7:0]         len_byte;

   assign go       = job_valid && (!valid_ff || rsp_ready);
   assign cur      = fresh_ff ? (job.hdr ? ihex_pkg::ST_COLON : ihex_pkg::ST_DATA_HI)
                              : step_ff;
   assign eof_k    = 4'(5'(cur) - 5'(ihex_pkg::ST_EOF0));
   assign len_byte = 8'(job.len);

   always_comb begin
      case (cur)
         ihex_pkg::ST_COLON:   ch = ihex_pkg::CHAR_COLON;
         ihex_pkg::ST_LEN_HI:  ch = ihex_pkg::hex_digit(len_byte[7:4]);
         ihex_pkg::ST_LEN_LO:  ch = ihex_pkg::hex_digit(len_byte[3:0]);
         ihex_pkg::ST_ADR3:    ch = ihex_pkg::hex_digit(job.addr[15:12]);
         ihex_pkg::ST_ADR2:    ch = ihex_pkg::hex_digit(job.addr[11:8]);
         ihex_pkg::ST_ADR1:    ch = ihex_pkg::hex_digit(job.addr[7:4]);
         ihex_pkg::ST_ADR0:    ch = ihex_pkg::hex_digit(job.addr[3:0]);
         ihex_pkg::ST_TYPE_HI: ch = ihex_pkg::CHAR_ZERO;
         ihex_pkg::ST_TYPE_LO: ch = ihex_pkg::CHAR_ZERO;
         ihex_pkg::ST_DATA_HI: ch = ihex_pkg::hex_digit(job.data[7:4]);
         ihex_pkg::ST_DATA_LO: ch = ihex_pkg::hex_digit(job.data[3:0]);
         ihex_pkg::ST_SUM_HI:  ch = ihex_pkg::hex_digit(job.csum[7:4]);
         ihex_pkg::ST_SUM_LO:  ch = ihex_pkg::hex_digit(job.csum[3:0]);
         ihex_pkg::ST_LF:      ch = ihex_pkg::CHAR_LF;
         default:              ch = ihex_pkg::eof_char(eof_k);
      endcase
   end

   always_comb begin
      finish = 1'b0;
      case (cur)
         ihex_pkg::ST_DATA_LO: finish = !job.trl;
         ihex_pkg::ST_LF:      finish = !job.eof;
         ihex_pkg::ST_EOF11:   finish = 1'b1;
         default:              finish = 1'b0;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      fresh_in = fresh_ff;
      if (go) begin
         if (finish) begin
            fresh_in = 1'b1;
         end else begin
            fresh_in = 1'b0;
            step_in  = ihex_pkg::step_type'(5'(cur) + 5'd1);
         end
      end
   end

   assign job_pop = go && finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ihex_pkg::ST_COLON;
         fresh_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         fresh_ff <= fresh_in;
         if (go) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         char_ff <= ch;
         last_ff <= finish;
         done_ff <= (cur == ihex_pkg::ST_EOF11);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_char_code  = char_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_image_done = done_ff;

endmodule

@@ hw/rtl/intel_hex_record_encoder.sv @@
// hex record encoder top: byte front end, job queue, character back end
// a byte is taken every cycle while the queue has room; output is registered
// unless stalled, the back end emits one character per cycle: 2 per byte, 9 more
// for a header, 3 more for checksum and line feed, 12 more for the end record
// synchronous active-high reset clears all control state, sets mode 0, count 1
// depends on ihex_pkg, ihex_front, ihex_queue, ihex_back
module intel_hex_record_encoder #(
   parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF,
   parameter int QUEUE_DEPTH      = ihex_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [6:0]                       rsp_char_code,
   output logic                             rsp_run_last,
   output logic                             rsp_image_done,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ihex_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ihex_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic              push_valid, push_ready;
   ihex_pkg::job_type push_job;
   logic              pop_valid, pop_ready;
   ihex_pkg::job_type pop_job;

   ihex_front #(
      .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .job_valid     (push_valid),
      .job           (push_job),
      .job_ready     (push_ready)
   );

   ihex_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   ihex_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job            (pop_job),
      .job_pop        (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_run_last   (rsp_run_last),
      .rsp_image_done (rsp_image_done)
   );

endmodule
